[rtl/nonuniform_grid_tridiag_coefficients_assert.svh]
// Assertion helpers; they compile to nothing in synthesis.
`ifndef NONUNIFORM_GRID_TRIDIAG_COEFFICIENTS_ASSERT_SVH
`define NONUNIFORM_GRID_TRIDIAG_COEFFICIENTS_ASSERT_SVH

`ifndef SYNTHESIS

`define NGTC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("ngtc: assertion failed");

`define NGTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("ngtc: assertion failed");

`else

`define NGTC_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`define NGTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[rtl/ngtc_pkg.sv]
package ngtc_pkg;

	localparam int MAX_POINTS_DEF = 4096;
	localparam int COORD_W = 32;
	localparam int COEF_W = 48;
	localparam int ROW_W = 12;
	localparam int MODE_W = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 48;
	// reciprocal quotient: 2^49 / 1 needs 50 bits
	localparam int Q_W = 50;

	localparam logic [MODE_W-1:0] MODE_AXIAL_IN = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RADIAL = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_AXIS_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TWO_OVER_DT = 1'd1;

	localparam logic [COEF_W-1:0] TOD_RESET = 48'd33554432;
	localparam logic [COEF_W-1:0] ONE_Q24 = 48'd16777216;
	localparam logic [COEF_W-1:0] MINUS_ONE_Q24 = ~ONE_Q24 + 48'd1;
	localparam logic [COEF_W-1:0] POS_MAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic [COEF_W-1:0] NEG_MIN = {1'b1, {(COEF_W-1){1'b0}}};
	localparam logic [Q_W-1:0] MAG_LIM = Q_W'(1) << (COEF_W - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_MUL_START,
		ST_MUL_WAIT,
		ST_DIAG,
		ST_EMIT_ROW,
		ST_EMIT_LAST
	} state_t;

	typedef enum logic [1:0] {
		OP_S,
		OP_H1,
		OP_H2,
		OP_R
	} recip_op_t;

	typedef struct packed {
		logic [COORD_W-1:0] coord;
		logic first_point;
		logic last_point;
	} pt_t;

	typedef struct packed {
		logic [ROW_W-1:0] row_index;
		logic signed [COEF_W-1:0] coef_sub;
		logic signed [COEF_W-1:0] coef_diag;
		logic signed [COEF_W-1:0] coef_super;
		logic div_fault;
		logic row_last;
	} row_t;

	typedef struct packed {
		logic start;
		logic wide_k;
		logic [COORD_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic start;
		logic [COEF_W-1:0] x;
		logic [Q_W-1:0] y;
	} mul_req_t;

	// Apply a sign to a magnitude and clip to the signed 48-bit range.
	function automatic logic [COEF_W-1:0] sign_sat(input logic [Q_W-1:0] mag, input logic neg);
		logic [COEF_W-1:0] res;
		if (neg) begin
			if (mag >= MAG_LIM) res = NEG_MIN;
			else res = ~{1'b0, mag[COEF_W-2:0]} + COEF_W'(1);
		end else begin
			if (mag >= MAG_LIM - Q_W'(1)) res = POS_MAX;
			else res = {1'b0, mag[COEF_W-2:0]};
		end
		return res;
	endfunction

endpackage

[rtl/ngtc_div.sv]
module ngtc_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ngtc_pkg::div_req_t       req,
	output logic                     done,
	output logic [ngtc_pkg::Q_W-1:0] quot
);

	localparam int DW = ngtc_pkg::COORD_W;
	localparam int QW = ngtc_pkg::Q_W;
	localparam int CNT_W = $clog2(QW + 1);
	// 2^k with k = 49 or 48 takes k+1 quotient bits
	localparam logic [CNT_W-1:0] STEPS_WIDE = CNT_W'(QW);
	localparam logic [CNT_W-1:0] STEPS_NARROW = CNT_W'(QW - 1);

	logic             busy_q;
	logic             done_q;
	logic             lead_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    dvs_q;
	logic [QW-1:0]    quot_q;

	logic [DW:0]   trial;
	logic          ge;
	logic [DW:0]   diff;
	logic [DW-1:0] rem_d;

	always_comb begin
		// the dividend is a single one followed by zeros
		trial = {rem_q, lead_q};
		ge = trial >= {1'b0, dvs_q};
		diff = trial - {1'b0, dvs_q};
		rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			lead_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				lead_q <= 1'b1;
				cnt_q <= req.wide_k ? STEPS_WIDE : STEPS_NARROW;
			end else if (busy_q) begin
				lead_q <= 1'b0;
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quot_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_d;
			quot_q <= {quot_q[QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

[rtl/ngtc_mul.sv]
module ngtc_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ngtc_pkg::mul_req_t          req,
	output logic                        done,
	output logic [ngtc_pkg::COEF_W-1:0] res
);

	localparam int CW = ngtc_pkg::COEF_W;
	localparam int QW = ngtc_pkg::Q_W;
	localparam int HALF = QW / 2;
	localparam int PW = 2 * QW;
	// product bits at or above this one overflow after the Q24 shift
	localparam int OVF_LSB = CW - 1 + 24;

	logic          busy_q;
	logic          done_q;
	logic [2:0]    step_q;
	logic [QW-1:0] mx_q;
	logic [QW-1:0] my_q;
	logic          neg_q;
	logic [PW-1:0] pp_q;
	logic [PW-1:0] acc_q;

	logic [QW-1:0]   mx_d;
	logic [QW-1:0]   my_d;
	logic [HALF-1:0] opa;
	logic [HALF-1:0] opb;
	logic [QW-1:0]   prod;
	logic [PW-1:0]   prod_sh;
	logic            ovf;
	logic [QW-1:0]   mag;

	always_comb begin
		mx_d = req.x[CW-1] ? ~{{(QW-CW){1'b1}}, req.x} + QW'(1) : {{(QW-CW){1'b0}}, req.x};
		my_d = req.y[QW-1] ? ~req.y + QW'(1) : req.y;
		opa = mx_q[HALF-1:0];
		opb = my_q[HALF-1:0];
		prod_sh = '0;
		prod = '0;
		case (step_q)
			3'd0: begin
				prod = opa * opb;
				prod_sh = PW'(prod);
			end
			3'd1: begin
				opb = my_q[QW-1:HALF];
				prod = opa * opb;
				prod_sh = PW'(prod) << HALF;
			end
			3'd2: begin
				opa = mx_q[QW-1:HALF];
				prod = opa * opb;
				prod_sh = PW'(prod) << HALF;
			end
			3'd3: begin
				opa = mx_q[QW-1:HALF];
				opb = my_q[QW-1:HALF];
				prod = opa * opb;
				prod_sh = PW'(prod) << (2 * HALF);
			end
			default: begin
				prod = '0;
				prod_sh = '0;
			end
		endcase
		ovf = |acc_q[PW-1:OVF_LSB];
		mag = ovf ? ngtc_pkg::MAG_LIM : QW'(acc_q[OVF_LSB-1:24]);
		res = ngtc_pkg::sign_sat(mag, neg_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// partial product registered, then added into the accumulator in the next cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			mx_q <= mx_d;
			my_q <= my_d;
			neg_q <= req.x[CW-1] ^ req.y[QW-1];
			acc_q <= '0;
		end else if (busy_q) begin
			pp_q <= prod_sh;
			if (step_q != 3'd0) acc_q <= acc_q + pp_q;
		end
	end

	assign done = done_q;

endmodule

[rtl/nonuniform_grid_tridiag_coefficients.sv]
// Interior row: the reciprocal divider (49-50 quotient bits per reciprocal, one per cycle)
// and two 5-step multiplies compute the row after accept. The next item can be
// accepted in the cycle after the row loads, unless that point was last. First-point rows,
// and the closing row of a second point, load once the row register is free; the closing
// row after an interior row loads once that row is taken. pt_ready is high only while idle.
// Reset (arst_n low) clears the sequencer, row_valid and grid history; mode 0, two_over_dt 2.0.
`include "nonuniform_grid_tridiag_coefficients_assert.svh"

module nonuniform_grid_tridiag_coefficients #(
	parameter int MAX_POINTS = ngtc_pkg::MAX_POINTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pt_valid,
	output logic                                pt_ready,
	input  ngtc_pkg::pt_t                       pt,
	output logic                                row_valid,
	input  logic                                row_ready,
	output ngtc_pkg::row_t                      row,
	input  logic                                cfg_we,
	input  logic [ngtc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ngtc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int CNT_W = $clog2(MAX_POINTS);
	localparam int ROW_W = ngtc_pkg::ROW_W;
	localparam int XW = ngtc_pkg::COORD_W;
	localparam int CW = ngtc_pkg::COEF_W;
	localparam int QW = ngtc_pkg::Q_W;
	localparam int SUM_W = CW + 3;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS - 1);

	ngtc_pkg::state_t    state_q, state_d;
	ngtc_pkg::recip_op_t op_q;
	logic                mul_c_q;
	logic                row_valid_q;
	ngtc_pkg::row_t      row_q, row_d;
	logic [ngtc_pkg::MODE_W-1:0] axis_mode_q;
	logic [CW-1:0]       tod_q;
	logic [XW-1:0]       prev_q;
	logic [XW-1:0]       prev2_q;
	logic [CNT_W-1:0]    cnt_q;

	logic [XW-1:0] x_q;
	logic          first_q;
	logic          last_q;
	logic          fault_q;
	logic [CW-1:0] inv_s_q;
	logic [QW-1:0] t1_q;
	logic [QW-1:0] t2_q;
	logic [CW-1:0] a_q;
	logic [CW-1:0] b_q;
	logic [CW-1:0] c_q;

	logic take;
	logic advance;
	logic div_cap;
	logic mul_cap;
	logic row_load;
	logic div_start;
	logic mul_start;
	logic [XW-1:0] adv_x;
	logic plain_first;

	logic [XW:0]    d_s, d_h1, d_h2, dsel, dneg;
	logic           dsign;
	logic [XW-1:0]  dmag;
	logic           dzero;
	logic [CW-1:0]  rv;
	logic [QW-1:0]  rv_x;
	logic [SUM_W-1:0] sum_b;
	logic [CW-1:0]  b_sat;

	ngtc_pkg::div_req_t div_req;
	logic               div_done;
	logic [QW-1:0]      div_quot;
	ngtc_pkg::mul_req_t mul_req;
	logic               mul_done;
	logic [CW-1:0]      mul_res;

	ngtc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	ngtc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.done   (mul_done),
		.res    (mul_res)
	);

	// divisor selection and sign handling for the reciprocal in progress
	always_comb begin
		d_s = {1'b0, x_q} - {1'b0, prev2_q};
		d_h1 = {1'b0, prev_q} - {1'b0, prev2_q};
		d_h2 = {1'b0, x_q} - {1'b0, prev_q};
		case (op_q)
			ngtc_pkg::OP_S:  dsel = d_s;
			ngtc_pkg::OP_H1: dsel = d_h1;
			ngtc_pkg::OP_H2: dsel = d_h2;
			default:         dsel = {1'b0, prev_q};
		endcase
		dsign = dsel[XW];
		dneg = ~dsel + (XW+1)'(1);
		dmag = dsign ? dneg[XW-1:0] : dsel[XW-1:0];
		dzero = (dmag == '0);
		rv = dzero ? ngtc_pkg::POS_MAX : ngtc_pkg::sign_sat(div_quot, dsign);
		rv_x = {{(QW-CW){rv[CW-1]}}, rv};

		div_req.start = div_start;
		div_req.wide_k = (op_q == ngtc_pkg::OP_H1) || (op_q == ngtc_pkg::OP_H2);
		div_req.divisor = dmag;

		mul_req.start = mul_start;
		mul_req.x = inv_s_q;
		mul_req.y = mul_c_q ? t2_q : t1_q;

		sum_b = '0 - {{3{a_q[CW-1]}}, a_q} - {{3{c_q[CW-1]}}, c_q} - {3'b000, tod_q};
		if (sum_b[SUM_W-1:CW-1] != {4{sum_b[SUM_W-1]}})
			b_sat = sum_b[SUM_W-1] ? ngtc_pkg::NEG_MIN : ngtc_pkg::POS_MAX;
		else
			b_sat = sum_b[CW-1:0];

		plain_first = pt.last_point || (axis_mode_q == ngtc_pkg::MODE_AXIAL_IN);
		adv_x = (state_q == ngtc_pkg::ST_IDLE) ? pt.coord : x_q;
	end

	always_comb begin
		state_d = state_q;
		pt_ready = 1'b0;
		take = 1'b0;
		advance = 1'b0;
		div_cap = 1'b0;
		mul_cap = 1'b0;
		row_load = 1'b0;
		div_start = 1'b0;
		mul_start = 1'b0;

		row_d.row_index = ROW_W'(cnt_q);
		row_d.coef_sub = a_q;
		row_d.coef_diag = b_q;
		row_d.coef_super = c_q;
		row_d.div_fault = fault_q;
		row_d.row_last = first_q & last_q;

		case (state_q)
			ngtc_pkg::ST_IDLE: begin
				pt_ready = 1'b1;
				if (pt_valid) begin
					take = 1'b1;
					if (pt.first_point) begin
						state_d = ngtc_pkg::ST_EMIT_ROW;
					end else if (cnt_q != '0) begin
						state_d = ngtc_pkg::ST_DIV_START;
					end else begin
						// second point: nothing to emit unless it closes the grid
						advance = 1'b1;
						state_d = pt.last_point ? ngtc_pkg::ST_EMIT_LAST : ngtc_pkg::ST_IDLE;
					end
				end
			end
			ngtc_pkg::ST_DIV_START: begin
				div_start = 1'b1;
				state_d = ngtc_pkg::ST_DIV_WAIT;
			end
			ngtc_pkg::ST_DIV_WAIT: begin
				if (div_done) begin
					div_cap = 1'b1;
					if (op_q == ngtc_pkg::OP_R ||
						(op_q == ngtc_pkg::OP_H2 && axis_mode_q != ngtc_pkg::MODE_RADIAL))
						state_d = ngtc_pkg::ST_MUL_START;
					else
						state_d = ngtc_pkg::ST_DIV_START;
				end
			end
			ngtc_pkg::ST_MUL_START: begin
				mul_start = 1'b1;
				state_d = ngtc_pkg::ST_MUL_WAIT;
			end
			ngtc_pkg::ST_MUL_WAIT: begin
				if (mul_done) begin
					mul_cap = 1'b1;
					state_d = mul_c_q ? ngtc_pkg::ST_DIAG : ngtc_pkg::ST_MUL_START;
				end
			end
			ngtc_pkg::ST_DIAG: begin
				state_d = ngtc_pkg::ST_EMIT_ROW;
			end
			ngtc_pkg::ST_EMIT_ROW: begin
				if (!row_valid_q || row_ready) begin
					row_load = 1'b1;
					if (first_q) begin
						state_d = ngtc_pkg::ST_IDLE;
					end else begin
						advance = 1'b1;
						state_d = last_q ? ngtc_pkg::ST_EMIT_LAST : ngtc_pkg::ST_IDLE;
					end
				end
			end
			ngtc_pkg::ST_EMIT_LAST: begin
				row_d.coef_sub = '0;
				row_d.coef_diag = ngtc_pkg::ONE_Q24;
				row_d.coef_super = '0;
				row_d.div_fault = 1'b0;
				row_d.row_last = 1'b1;
				if (!row_valid_q || row_ready) begin
					row_load = 1'b1;
					state_d = ngtc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ngtc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ngtc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= 1'b0;
			axis_mode_q <= ngtc_pkg::MODE_AXIAL_IN;
			tod_q <= ngtc_pkg::TOD_RESET;
			prev_q <= '0;
			prev2_q <= '0;
			cnt_q <= '0;
			op_q <= ngtc_pkg::OP_S;
			mul_c_q <= 1'b0;
		end else begin
			if (row_load) row_valid_q <= 1'b1;
			else if (row_ready) row_valid_q <= 1'b0;

			if (cfg_we) begin
				case (cfg_index)
					ngtc_pkg::REG_AXIS_MODE:   axis_mode_q <= cfg_data[ngtc_pkg::MODE_W-1:0];
					ngtc_pkg::REG_TWO_OVER_DT: tod_q <= cfg_data[CW-1:0];
					default: ;
				endcase
			end

			if (take) begin
				op_q <= ngtc_pkg::OP_S;
				mul_c_q <= 1'b0;
			end
			if (take && pt.first_point) begin
				prev_q <= pt.coord;
				prev2_q <= pt.coord;
				cnt_q <= '0;
			end else if (advance) begin
				prev2_q <= prev_q;
				prev_q <= adv_x;
				if (cnt_q < CNT_MAX) cnt_q <= cnt_q + CNT_W'(1);
			end

			if (div_cap) begin
				case (op_q)
					ngtc_pkg::OP_S:  op_q <= ngtc_pkg::OP_H1;
					ngtc_pkg::OP_H1: op_q <= ngtc_pkg::OP_H2;
					ngtc_pkg::OP_H2: op_q <= ngtc_pkg::OP_R;
					default:         op_q <= ngtc_pkg::OP_S;
				endcase
			end
			if (mul_cap) mul_c_q <= ~mul_c_q;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			x_q <= pt.coord;
			first_q <= pt.first_point;
			last_q <= pt.last_point;
			fault_q <= 1'b0;
			if (pt.first_point) begin
				a_q <= '0;
				b_q <= plain_first ? ngtc_pkg::ONE_Q24 : ngtc_pkg::MINUS_ONE_Q24;
				c_q <= plain_first ? '0 : ngtc_pkg::ONE_Q24;
			end
		end
		if (div_cap) begin
			fault_q <= fault_q | dzero;
			case (op_q)
				ngtc_pkg::OP_S:  inv_s_q <= rv;
				ngtc_pkg::OP_H1: t1_q <= rv_x;
				ngtc_pkg::OP_H2: t2_q <= rv_x;
				default: begin
					// fold in the 1/r terms
					t1_q <= t1_q - rv_x;
					t2_q <= t2_q + rv_x;
				end
			endcase
		end
		if (mul_cap) begin
			if (mul_c_q) c_q <= mul_res;
			else a_q <= mul_res;
		end
		if (state_q == ngtc_pkg::ST_DIAG) b_q <= b_sat;
		if (row_load) row_q <= row_d;
	end

	assign row_valid = row_valid_q;
	assign row = row_q;

	`NGTC_ASSERT_IMP(a_div_done_in_wait, clk, arst_n, div_done, state_q == ngtc_pkg::ST_DIV_WAIT)
	`NGTC_ASSERT_IMP(a_mul_done_in_wait, clk, arst_n, mul_done, state_q == ngtc_pkg::ST_MUL_WAIT)
	`NGTC_ASSERT_IMP(a_last_row_shape, clk, arst_n, row_valid && row.row_last, row.coef_sub == '0 && row.coef_super == '0 && row.coef_diag == ngtc_pkg::ONE_Q24)
	`NGTC_ASSERT_NEXT(a_first_restarts, clk, arst_n, pt_valid && pt_ready && pt.first_point, state_q == ngtc_pkg::ST_EMIT_ROW && cnt_q == '0)

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

	localparam logic [ngtc_pkg::MODE_W-1:0] MODE_AXIAL_OUT = 2'd1;
	localparam logic [ngtc_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
	localparam int POINT_CAP = ngtc_pkg::MAX_POINTS_DEF;
	localparam int DRAIN_CYCLES = 300;
	localparam int RANDOM_POINTS = 1800;
	localparam int HOLD_OFF_CYCLES = 2000;
	localparam longint POS48 = 64'sh7FFF_FFFF_FFFF;
	localparam longint NEG48 = -64'sh8000_0000_0000;
	localparam longint ONE_Q = longint'(ngtc_pkg::ONE_Q24);

	logic clk;
	logic arst_n;
	logic pt_valid;
	logic pt_ready;
	ngtc_pkg::pt_t pt_in;
	logic row_valid;
	logic row_ready;
	ngtc_pkg::row_t row_out;
	logic cfg_we;
	logic [ngtc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ngtc_pkg::CFG_DATA_W-1:0] cfg_data;

	// shadow of the grid history and registers
	logic [ngtc_pkg::COORD_W-1:0] grid_x0;
	logic [ngtc_pkg::COORD_W-1:0] grid_x1;
	int grid_idx;
	logic [ngtc_pkg::MODE_W-1:0] cur_mode;
	logic [ngtc_pkg::COEF_W-1:0] cur_tod;

	ngtc_pkg::row_t rows_due[$];
	int mismatches;
	int points_sent;
	bit bubbles_on;
	int hold_left;

	nonuniform_grid_tridiag_coefficients DUT (
		.clk(clk),
		.arst_n(arst_n),
		.pt_valid(pt_valid),
		.pt_ready(pt_ready),
		.pt(pt_in),
		.row_valid(row_valid),
		.row_ready(row_ready),
		.row(row_out),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic longint clip48(input longint v);
		if (v > POS48) return POS48;
		if (v < NEG48) return NEG48;
		return v;
	endfunction

	function automatic longint signed_mag(input logic [63:0] mag, input bit neg);
		if (neg) return (mag >= 64'h8000_0000_0000) ? NEG48 : -longint'(mag);
		return (mag >= 64'h7FFF_FFFF_FFFF) ? POS48 : longint'(mag);
	endfunction

	// 2^k / d in Q24.24, truncated magnitude
	function automatic longint recip_q(input int k, input longint d);
		logic [63:0] mag;
		if (d == 0) return POS48;
		mag = (d < 0) ? 64'(-d) : 64'(d);
		return signed_mag((64'd1 << k) / mag, d < 0);
	endfunction

	function automatic longint mul_q(input longint x, input longint y);
		bit neg;
		logic [63:0] mx;
		logic [63:0] my;
		logic [127:0] prod;
		neg = (x < 0) != (y < 0);
		mx = (x < 0) ? 64'(-x) : 64'(x);
		my = (y < 0) ? 64'(-y) : 64'(y);
		prod = {64'd0, mx} * {64'd0, my};
		if (prod >= (128'd1 << 71)) return neg ? NEG48 : POS48;
		return signed_mag(prod[87:24], neg);
	endfunction

	function automatic void push_row(input int idx, input longint a, input longint b,
			input longint c, input bit fault, input bit is_last);
		ngtc_pkg::row_t r;
		r.row_index = 12'(idx);
		r.coef_sub = a[47:0];
		r.coef_diag = b[47:0];
		r.coef_super = c[47:0];
		r.div_fault = fault;
		r.row_last = is_last;
		rows_due.push_back(r);
	endfunction

	function automatic void predict_rows(input ngtc_pkg::pt_t p);
		longint x0, x1, x2, ds, d1, d2;
		longint inv_s, t1, t2, inv_r, a, b, c;
		bit fault;
		if (p.first_point) begin
			grid_x0 = p.coord;
			grid_x1 = p.coord;
			grid_idx = 0;
			if (p.last_point || cur_mode == ngtc_pkg::MODE_AXIAL_IN)
				push_row(0, 0, ONE_Q, 0, 1'b0, p.last_point);
			else
				push_row(0, 0, -ONE_Q, ONE_Q, 1'b0, 1'b0);
			return;
		end
		if (grid_idx >= 1) begin
			x0 = longint'({32'd0, grid_x0});
			x1 = longint'({32'd0, grid_x1});
			x2 = longint'({32'd0, p.coord});
			ds = x2 - x0;
			d1 = x1 - x0;
			d2 = x2 - x1;
			fault = (ds == 0) || (d1 == 0) || (d2 == 0);
			inv_s = recip_q(48, ds);
			t1 = recip_q(49, d1);
			t2 = recip_q(49, d2);
			if (cur_mode == ngtc_pkg::MODE_RADIAL) begin
				inv_r = recip_q(48, x1);
				fault |= (x1 == 0);
				t1 -= inv_r;
				t2 += inv_r;
			end
			a = mul_q(inv_s, t1);
			c = mul_q(inv_s, t2);
			b = clip48(-a - c - longint'({16'd0, cur_tod}));
			push_row(grid_idx, a, b, c, fault, 1'b0);
		end
		if (grid_idx < POINT_CAP - 1) grid_idx++;
		grid_x0 = grid_x1;
		grid_x1 = p.coord;
		if (p.last_point) push_row(grid_idx, 0, ONE_Q, 0, 1'b0, 1'b1);
	endfunction

	task automatic send_point(input logic [31:0] x, input bit is_first, input bit is_last);
		ngtc_pkg::pt_t p;
		p.coord = x;
		p.first_point = is_first;
		p.last_point = is_last;
		while (bubbles_on && $urandom_range(99) < 19) begin
			pt_valid <= 1'b0;
			@(posedge clk);
		end
		pt_valid <= 1'b1;
		pt_in <= p;
		@(posedge clk);
		while (!pt_ready) @(posedge clk);
		predict_rows(p);
		points_sent++;
	endtask

	// drain all rows, then let the sequencer settle before touching a register
	task automatic write_reg(input logic [ngtc_pkg::CFG_IDX_W-1:0] idx,
			input logic [ngtc_pkg::CFG_DATA_W-1:0] data);
		pt_valid <= 1'b0;
		while (rows_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == ngtc_pkg::REG_AXIS_MODE) cur_mode = data[1:0];
		else cur_tod = data[47:0];
	endtask

	function automatic logic [31:0] next_gap();
		case ($urandom_range(19))
			0: return 32'd0;
			1: return -32'($urandom_range(1, 1 << 20));
			2, 3: return 32'($urandom_range(1, 15));
			4: return $urandom();
			default: return 32'($urandom_range(1 << 12, 1 << 25));
		endcase
	endfunction

	task automatic send_grid(input int len, input bit with_first, input bit with_last,
			input bit narrow);
		logic [31:0] x;
		x = ($urandom_range(3) == 0) ? 32'd0 : 32'($urandom_range(0, 1 << 26));
		for (int i = 0; i < len; i++) begin
			send_point(x, with_first && i == 0, with_last && i == len - 1);
			x += narrow ? 32'($urandom_range(1, 1 << 19)) : next_gap();
		end
	endtask

	// reset acts as a first point at zero
	task automatic test_reset_history();
		send_point(32'h0100_0000, 1'b0, 1'b0);
		send_point(32'h0300_0000, 1'b0, 1'b0);
		send_point(32'h0400_0000, 1'b0, 1'b1);
	endtask

	task automatic test_boundary_modes();
		logic [ngtc_pkg::MODE_W-1:0] modes [4];
		logic [ngtc_pkg::COEF_W-1:0] tods [4];
		modes = '{ngtc_pkg::MODE_AXIAL_IN, MODE_AXIAL_OUT, ngtc_pkg::MODE_RADIAL, MODE_SPARE};
		tods = '{48'd0, ngtc_pkg::TOD_RESET, 48'h0000_1234_5678, 48'hFFFF_FFFF_FFFF};
		for (int m = 0; m < 4; m++) begin
			write_reg(ngtc_pkg::REG_AXIS_MODE, 48'(modes[m]));
			write_reg(ngtc_pkg::REG_TWO_OVER_DT, tods[m]);
			send_point(32'h0080_0000, 1'b1, 1'b0);
			send_point(32'h0100_0000, 1'b0, 1'b0);
			send_point(32'h0200_0000, 1'b0, 1'b1);
		end
		// first and last on the same item
		send_point(32'hFFFF_FFFF, 1'b1, 1'b1);
	endtask

	task automatic test_division_faults();
		write_reg(ngtc_pkg::REG_AXIS_MODE, 48'(ngtc_pkg::MODE_RADIAL));
		write_reg(ngtc_pkg::REG_TWO_OVER_DT, ngtc_pkg::TOD_RESET);
		send_point(32'h0100_0000, 1'b1, 1'b0);
		send_point(32'h0000_0000, 1'b0, 1'b0);
		send_point(32'h0200_0000, 1'b0, 1'b0);
		send_point(32'h0200_0000, 1'b0, 1'b0);
		send_point(32'hFFFF_FFFF, 1'b0, 1'b1);
		// one-ulp spacing and radius
		send_point(32'h0000_0000, 1'b1, 1'b0);
		send_point(32'h0000_0001, 1'b0, 1'b0);
		send_point(32'h0000_0002, 1'b0, 1'b1);
	endtask

	// stall the row side long enough that the input backs up
	task automatic test_backpressure();
		write_reg(ngtc_pkg::REG_AXIS_MODE, 48'(MODE_AXIAL_OUT));
		hold_left = HOLD_OFF_CYCLES;
		send_point(32'h0010_0000, 1'b1, 1'b0);
		for (int i = 1; i < 10; i++)
			send_point(32'h0010_0000 * (i + 1), 1'b0, i == 9);
	endtask

	task automatic random_config();
		logic [ngtc_pkg::COEF_W-1:0] tod;
		case ($urandom_range(5))
			0: tod = '0;
			1: tod = '1;
			default: tod = 48'({$urandom(), $urandom()} >> $urandom_range(0, 40));
		endcase
		write_reg(ngtc_pkg::REG_AXIS_MODE, 48'($urandom_range(3)));
		write_reg(ngtc_pkg::REG_TWO_OVER_DT, tod);
	endtask

	task automatic test_random_grids();
		int base;
		int grids;
		int choice;
		int len;
		base = points_sent;
		grids = 0;
		while (points_sent - base < RANDOM_POINTS) begin
			if (grids % 12 == 0) random_config();
			bubbles_on = !(points_sent - base >= 700 && points_sent - base < 1000);
			choice = $urandom_range(99);
			len = $urandom_range(1, 12);
			if (choice < 75)
				send_grid(len, 1'b1, 1'b1, 1'b0);
			else if (choice < 87)
				send_grid(len, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0);
			else
				repeat ($urandom_range(1, 4))
					send_point($urandom(), $urandom_range(3) == 0, $urandom_range(3) == 0);
			grids++;
		end
		bubbles_on = 1'b1;
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			row_ready <= 1'b0;
		end else begin
			row_ready <= !(bubbles_on && $urandom_range(99) < 19);
		end
	end

	always @(posedge clk) begin
		ngtc_pkg::row_t want;
		if (arst_n && row_valid && row_ready) begin
			if (rows_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected row: idx=%0d a=%0d b=%0d c=%0d f=%0b l=%0b",
						row_out.row_index, $signed(row_out.coef_sub),
						$signed(row_out.coef_diag), $signed(row_out.coef_super),
						row_out.div_fault, row_out.row_last);
			end else begin
				want = rows_due.pop_front();
				if (row_out.row_index !== want.row_index ||
						row_out.coef_sub !== want.coef_sub ||
						row_out.coef_diag !== want.coef_diag ||
						row_out.coef_super !== want.coef_super ||
						row_out.div_fault !== want.div_fault ||
						row_out.row_last !== want.row_last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("row mismatch expected: idx=%0d a=%0d b=%0d c=%0d f=%0b l=%0b",
							want.row_index, $signed(want.coef_sub), $signed(want.coef_diag),
							$signed(want.coef_super), want.div_fault, want.row_last);
						$display("               actual: idx=%0d a=%0d b=%0d c=%0d f=%0b l=%0b",
							row_out.row_index, $signed(row_out.coef_sub),
							$signed(row_out.coef_diag), $signed(row_out.coef_super),
							row_out.div_fault, row_out.row_last);
					end
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		pt_valid = 1'b0;
		pt_in = '0;
		row_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		grid_x0 = '0;
		grid_x1 = '0;
		grid_idx = 0;
		cur_mode = ngtc_pkg::MODE_AXIAL_IN;
		cur_tod = ngtc_pkg::TOD_RESET;
		mismatches = 0;
		points_sent = 0;
		bubbles_on = 1'b1;
		hold_left = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_history();
		test_boundary_modes();
		test_division_faults();
		test_backpressure();
		test_random_grids();

		pt_valid <= 1'b0;
		while (rows_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && rows_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#(100_000_000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/ngtc_pkg.sv
rtl/ngtc_div.sv
rtl/ngtc_mul.sv
rtl/nonuniform_grid_tridiag_coefficients.sv
tb/tb_top.sv
